FILE: rtl/pl_pkg.sv
// Package for the positional list engine: sizes, command codes and the
// controller-to-datapath command struct. No dependencies.
package pl_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CMD_W  = 3;

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ERASE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FIND   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;  // capture the input transaction
    logic exec;  // run the operation and load the result register
  } dp_cmd_t;

endpackage

FILE: rtl/positional_list_engine_top.sv
// Positional list engine: ordered list of up to 16 words with insert, erase,
// get, find and clear. A transaction is captured in the IDLE state; the EXEC
// state runs the shift/compare step and loads the result register. No new
// transaction is accepted until it has run; EXEC waits on a stalled result.
// Reset (rst_ni low, asynchronous) empties the list and sets the capacity to 16;
// slot contents are not cleared. Depends on pl_pkg, pl_ctrl and pl_datapath.
module positional_list_engine_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_wr_en_i,
  input  logic [4:0]                cfg_wr_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [2:0]                cmd_i,
  input  logic [4:0]                position_i,
  input  logic [31:0]               element_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      ok_o,
  output logic [31:0]               read_word_o,
  output logic signed [4:0]         found_index_o,
  output logic [4:0]                count_o,
  output logic                      full_res_o
);

  pl_pkg::dp_cmd_t dp_cmd;

  // Sequencing and handshakes
  pl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (dp_cmd)
  );

  // Storage and list operations
  pl_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .op_i          (cmd_i),
    .position_i    (position_i),
    .element_i     (element_i),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .ok_o          (ok_o),
    .read_word_o   (read_word_o),
    .found_index_o (found_index_o),
    .count_o       (count_o),
    .full_res_o    (full_res_o)
  );

endmodule

FILE: rtl/pl_datapath.sv
// Datapath of the positional list engine: slot registers, entry count,
// capacity register, shift/compare logic and the result register. Uses pl_pkg.
module pl_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pl_pkg::dp_cmd_t               cmd_i,
  input  logic [pl_pkg::CMD_W-1:0]      op_i,
  input  logic [4:0]                    position_i,
  input  logic [pl_pkg::WORD_W-1:0]     element_i,
  input  logic                          cfg_wr_en_i,
  input  logic [4:0]                    cfg_wr_data_i,
  output logic                          ok_o,
  output logic [pl_pkg::WORD_W-1:0]     read_word_o,
  output logic signed [4:0]             found_index_o,
  output logic [4:0]                    count_o,
  output logic                          full_res_o
);

  logic [pl_pkg::WORD_W-1:0] slots_q [pl_pkg::DEPTH];
  logic [pl_pkg::WORD_W-1:0] slots_d [pl_pkg::DEPTH];
  logic [pl_pkg::CNT_W-1:0]  count_q, count_d;
  logic [4:0]                cap_q;
  logic [pl_pkg::CMD_W-1:0]  op_q;
  logic [4:0]                pos_q;
  logic [pl_pkg::WORD_W-1:0] elem_q;

  logic [pl_pkg::CNT_W-1:0]  eff_cap;
  logic [pl_pkg::DEPTH-1:0]  match;
  logic                      any_match;
  logic [pl_pkg::IDX_W-1:0]  first_idx;
  logic                      ok_d;
  logic [pl_pkg::WORD_W-1:0] rd_d;
  logic signed [4:0]         found_d;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= pl_pkg::CAP_RESET;
    end else if (cfg_wr_en_i) begin
      cap_q <= cfg_wr_data_i;
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      pos_q  <= position_i;
      elem_q <= element_i;
    end
  end

  // Clamp the capacity to the slot count
  assign eff_cap = (cap_q > pl_pkg::CNT_W'(pl_pkg::DEPTH)) ?
                   pl_pkg::CNT_W'(pl_pkg::DEPTH) : cap_q;

  // Compare every live slot against the search word
  always_comb begin
    for (int i = 0; i < pl_pkg::DEPTH; i++) begin
      match[i] = (pl_pkg::CNT_W'(i) < count_q) && (slots_q[i] == elem_q);
    end
  end

  // Pick the lowest matching slot
  always_comb begin
    any_match = 1'b0;
    first_idx = '0;
    for (int i = pl_pkg::DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        any_match = 1'b1;
        first_idx = pl_pkg::IDX_W'(i);
      end
    end
  end

  // Operation: shifts, count update and result fields
  always_comb begin
    slots_d = slots_q;
    count_d = count_q;
    ok_d    = 1'b0;
    rd_d    = '0;
    found_d = '0;
    unique case (op_q)
      pl_pkg::CMD_INSERT: begin
        if ((pos_q <= count_q) && (count_q < eff_cap)
            && (count_q < pl_pkg::CNT_W'(pl_pkg::DEPTH))) begin
          for (int i = 0; i < pl_pkg::DEPTH; i++) begin
            if (pl_pkg::CNT_W'(i) == pos_q) begin
              slots_d[i] = elem_q;
            end else if (i > 0 && pl_pkg::CNT_W'(i) > pos_q
                         && pl_pkg::CNT_W'(i) <= count_q) begin
              slots_d[i] = slots_q[(i > 0) ? i - 1 : 0];
            end
          end
          count_d = count_q + 1'b1;
          ok_d    = 1'b1;
        end
      end
      pl_pkg::CMD_ERASE: begin
        if (pos_q < count_q) begin
          for (int i = 0; i < pl_pkg::DEPTH - 1; i++) begin
            if (pl_pkg::CNT_W'(i) >= pos_q && pl_pkg::CNT_W'(i + 1) < count_q) begin
              slots_d[i] = slots_q[i + 1];
            end
          end
          count_d = count_q - 1'b1;
          ok_d    = 1'b1;
        end
      end
      pl_pkg::CMD_GET: begin
        if (pos_q < count_q) begin
          rd_d = slots_q[pos_q[pl_pkg::IDX_W-1:0]];
          ok_d = 1'b1;
        end
      end
      pl_pkg::CMD_FIND: begin
        ok_d    = any_match;
        found_d = any_match ? signed'({1'b0, first_idx}) : '1;
      end
      pl_pkg::CMD_CLEAR: begin
        count_d = '0;
        ok_d    = 1'b1;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  // Entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  // Slot registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      for (int i = 0; i < pl_pkg::DEPTH; i++) begin
        slots_q[i] <= slots_d[i];
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      ok_o          <= ok_d;
      read_word_o   <= rd_d;
      found_index_o <= found_d;
      count_o       <= count_d;
      full_res_o    <= (count_d >= eff_cap);
    end
  end

endmodule

FILE: rtl/pl_ctrl.sv
// Controller of the positional list engine: input/output handshakes and
// sequencing of the datapath. Uses pl_pkg.
module pl_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output pl_pkg::dp_cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic exec;

  // Run once the result register is free or being drained
  assign exec = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign cmd_o.load   = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.exec   = exec;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold the result until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (exec) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
